// File: sv/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants for the refcounted slot pool.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int SLOTS        = 16;
  localparam int BORROW_BITS  = 16;
  localparam int SLOT_IDX_W   = $clog2(SLOTS);
  localparam int TOTAL_W      = $clog2(SLOTS + 1);
  localparam int SLOT_FIELD_W = 4;
  localparam int USE_FIELD_W  = 5;
  localparam int CAP_W        = 32;

  localparam logic [CAP_W-1:0] BUFFER_BYTES_RESET = CAP_W'(4096);

  localparam logic [1:0] KIND_ACQUIRE  = 2'd0;
  localparam logic [1:0] KIND_RETAIN   = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_SEAL     = 2'd3;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef logic [SLOT_IDX_W-1:0]  slot_idx_t;
  typedef logic [BORROW_BITS-1:0] borrow_t;
  typedef logic [TOTAL_W-1:0]     total_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [SLOT_FIELD_W-1:0] slot;
  } rsp_in_t;

  typedef struct packed {
    logic                    status;
    logic [SLOT_FIELD_W-1:0] granted_slot;
    logic [CAP_W-1:0]        capacity;
    logic                    released;
    logic [USE_FIELD_W-1:0]  slots_in_use;
  } rsp_out_t;

  // Result of one operation on the slot table, before capacity is attached.
  typedef struct packed {
    logic                    status;
    logic                    granted;
    logic [SLOT_FIELD_W-1:0] granted_slot;
    logic                    released;
    logic [USE_FIELD_W-1:0]  slots_in_use;
  } rsp_res_t;

endpackage

// File: sv/refcounted_slot_pool_unit.sv
// ----------------------------------------------------------------------------
// refcounted_slot_pool_unit
// Round-robin buffer slot pool with per-slot borrow counts.
// ----------------------------------------------------------------------------
// Accepts one item per cycle unless in_stall is high; an item passes the input
// register, then the result register. Every operation, including
// the round-robin free-slot search, completes combinationally between
// the two registers, so the slot table is updated as each item advances and the
// next item sees it. cfg_ready is always high; buffer_bytes resets to 4096.
module refcounted_slot_pool_unit
  import rsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rsp_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rsp_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data
);

  logic             a_valid_r;
  rsp_in_t          a_data_r;
  logic             b_valid_r;
  rsp_out_t         b_data_r;
  logic [CAP_W-1:0] bytes_r;
  logic             b_free, a_adv, in_take;
  rsp_res_t         res;

  assign b_free    = !b_valid_r || !out_stall;
  assign a_adv     = a_valid_r && b_free;
  assign in_stall  = a_valid_r && !b_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = b_valid_r;
  assign out_data  = b_data_r;

  rsp_slot_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .op_en (a_adv),
    .op    (a_data_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      bytes_r   <= BUFFER_BYTES_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bytes_r <= cfg_data;
      end
      if (in_take) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        b_valid_r <= 1'b1;
      end else if (!out_stall) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_data_r <= in_data;
    end
    if (a_adv) begin
      b_data_r.status       <= res.status;
      b_data_r.granted_slot <= res.granted_slot;
      b_data_r.capacity     <= res.granted ? bytes_r : '0;
      b_data_r.released     <= res.released;
      b_data_r.slots_in_use <= res.slots_in_use;
    end
  end

endmodule

// File: sv/rsp_free_search.sv
// ----------------------------------------------------------------------------
// rsp_free_search
// Rotated priority encoder: first free slot at or after the start pointer.
// ----------------------------------------------------------------------------
module rsp_free_search
  import rsp_pkg::*;
(
  input  logic [SLOTS-1:0] occupied,
  input  slot_idx_t        start,
  output logic             found,
  output slot_idx_t        slot_idx
);

  logic [2*SLOTS-1:0] free_dbl;
  logic [SLOTS-1:0]   free_rot;
  slot_idx_t          offset;
  logic [SLOT_IDX_W:0] sum;

  always_comb begin
    free_dbl = {~occupied, ~occupied} >> start;
    free_rot = free_dbl[SLOTS-1:0];
    found    = |free_rot;
    offset   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_rot[i]) begin
        offset = SLOT_IDX_W'(i);
      end
    end
    sum = {1'b0, start} + {1'b0, offset};
    if (sum >= (SLOT_IDX_W + 1)'(SLOTS)) begin
      sum = sum - (SLOT_IDX_W + 1)'(SLOTS);
    end
    slot_idx = sum[SLOT_IDX_W-1:0];
  end

endmodule

// File: sv/rsp_slot_table.sv
// ----------------------------------------------------------------------------
// rsp_slot_table
// Per-slot in-use, sealed and borrow state; executes one operation a cycle while op_en is high.
// ----------------------------------------------------------------------------
module rsp_slot_table
  import rsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     op_en,
  input  rsp_in_t  op,
  output rsp_res_t res
);

  logic [SLOTS-1:0] occ_r,  occ_nxt;
  logic [SLOTS-1:0] seal_r, seal_nxt;
  borrow_t          cnt_r [SLOTS];
  borrow_t          cnt_nxt [SLOTS];
  slot_idx_t        start_r, start_nxt;
  total_t           total_r, total_nxt;

  logic      found;
  slot_idx_t free_idx;
  slot_idx_t s;
  logic      in_range;
  logic      sel_occ, sel_seal;
  borrow_t   sel_cnt;
  logic      ok, rel;

  rsp_free_search u_search (
    .occupied (occ_r),
    .start    (start_r),
    .found    (found),
    .slot_idx (free_idx)
  );

  always_comb begin
    s        = op.slot[SLOT_IDX_W-1:0];
    in_range = (32'(op.slot) < 32'(SLOTS));
    sel_occ  = occ_r[s];
    sel_seal = seal_r[s];
    sel_cnt  = cnt_r[s];

    occ_nxt   = occ_r;
    seal_nxt  = seal_r;
    cnt_nxt   = cnt_r;
    start_nxt = start_r;
    total_nxt = total_r;
    ok        = 1'b0;
    rel       = 1'b0;

    case (op.kind)
      KIND_ACQUIRE: begin
        if (found) begin
          ok                 = 1'b1;
          occ_nxt[free_idx]  = 1'b1;
          seal_nxt[free_idx] = 1'b0;
          cnt_nxt[free_idx]  = '0;
          total_nxt          = total_r + total_t'(1);
          start_nxt          = (free_idx == slot_idx_t'(SLOTS - 1)) ? '0
                                                                    : free_idx + slot_idx_t'(1);
        end
      end
      KIND_RETAIN: begin
        if (in_range && sel_occ && !sel_seal && (sel_cnt != '1)) begin
          ok         = 1'b1;
          cnt_nxt[s] = sel_cnt + borrow_t'(1);
        end
      end
      KIND_COMPLETE: begin
        if (in_range && sel_occ && (sel_cnt != '0)) begin
          ok         = 1'b1;
          cnt_nxt[s] = sel_cnt - borrow_t'(1);
          rel        = sel_seal && (sel_cnt == borrow_t'(1));
        end
      end
      KIND_SEAL: begin
        if (in_range && sel_occ && !sel_seal) begin
          ok          = 1'b1;
          seal_nxt[s] = 1'b1;
          rel         = (sel_cnt == '0);
        end
      end
      default: ;
    endcase

    if (rel) begin
      occ_nxt[s]  = 1'b0;
      seal_nxt[s] = 1'b0;
      total_nxt   = total_r - total_t'(1);
    end

    res.status       = ok ? STATUS_OK : STATUS_REFUSED;
    res.granted      = ok && (op.kind == KIND_ACQUIRE);
    res.granted_slot = res.granted ? SLOT_FIELD_W'(free_idx) : '0;
    res.released     = rel;
    res.slots_in_use = USE_FIELD_W'(total_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      seal_r  <= '0;
      start_r <= '0;
      total_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (op_en) begin
      occ_r   <= occ_nxt;
      seal_r  <= seal_nxt;
      start_r <= start_nxt;
      total_r <= total_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule

// File: sv/rsp_checker.sv
// ----------------------------------------------------------------------------
// rsp_checker
// Port-level checks for the refcounted slot pool, bound to the top level.
// ----------------------------------------------------------------------------
module rsp_checker
  import rsp_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input rsp_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_REFUSED) |->
      (out_data.granted_slot == '0) && (out_data.capacity == '0) && !out_data.released)
    else $error("refused item carries grant or release");

  a_release_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.released |->
      (out_data.status == STATUS_OK) && (out_data.granted_slot == '0)
      && (out_data.capacity == '0))
    else $error("release reported together with a grant");

  a_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.slots_in_use) <= 32'(SLOTS)))
    else $error("slots in use exceeds pool size");

endmodule

bind refcounted_slot_pool_unit rsp_checker u_rsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
